### rtl/core/u8v_pkg.sv
// u8v_pkg: shared types, constants and decode functions for the utf-8 copier
// used by u8v_front, u8v_queue, u8v_back and utf8_validating_copier
`timescale 1ns / 1ps

package u8v_pkg;

  localparam int TEXT_MAX_DEF = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;

  localparam logic [20:0] CP_DEL        = 21'h00007f;
  localparam logic [20:0] CP_SPACE      = 21'h000020;
  localparam logic [20:0] CP_MIN2       = 21'h000080;
  localparam logic [20:0] CP_MIN3       = 21'h000800;
  localparam logic [20:0] CP_SURR_LO    = 21'h00d800;
  localparam logic [20:0] CP_SURR_HI    = 21'h00dfff;
  localparam logic [20:0] CP_MIN4       = 21'h010000;
  localparam logic [20:0] CP_MAX        = 21'h10ffff;

  typedef enum logic [1:0] {
    PH_RUN  = 2'd0,
    PH_FULL = 2'd1,
    PH_FAIL = 2'd2
  } phase_t;

  typedef enum logic {
    KIND_TEXT   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // one queued job: a whole character or the final status
  typedef struct packed {
    kind_t           kind;
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            status;
    logic [6:0]      length;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b < 8'h80) n = 3'd1;
    else if (b inside {[8'hc2:8'hdf]}) n = 3'd2;
    else if (b inside {[8'he0:8'hef]}) n = 3'd3;
    else if (b inside {[8'hf0:8'hf4]}) n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] lead_payload(input logic [7:0] b, input logic [2:0] n);
    logic [7:0] v;
    case (n)
      3'd2:    v = b & 8'h1f;
      3'd3:    v = b & 8'h0f;
      3'd4:    v = b & 8'h07;
      default: v = b;
    endcase
    return v;
  endfunction

  function automatic logic char_bad(input logic [20:0] cp, input logic [2:0] n);
    logic bad;
    bad = (cp < CP_SPACE) || (cp == CP_DEL);
    if (n == 3'd2 && cp < CP_MIN2) bad = 1'b1;
    if (n == 3'd3 && (cp < CP_MIN3 || (cp >= CP_SURR_LO && cp <= CP_SURR_HI))) bad = 1'b1;
    if (n == 3'd4 && (cp < CP_MIN4 || cp > CP_MAX)) bad = 1'b1;
    if (n == 3'd0 || n > 3'd4) bad = 1'b1;
    return bad;
  endfunction

endpackage

### rtl/core/u8v_front.sv
// u8v_front: accepts bytes, gathers and checks characters, counts the copy
// and pushes whole characters and the final status into the job queue; uses u8v_pkg
`timescale 1ns / 1ps

module u8v_front import u8v_pkg::*; #(
  parameter int TEXT_MAX = TEXT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  qstat_t     qstat,
  output logic       push,
  output job_t       push_job
);

  localparam int CNT_W = $clog2(TEXT_MAX + 1);

  logic [3:0][7:0] pend, pend_next;
  logic [2:0]      expected_len, expected_len_next;
  logic [2:0]      seen_len, seen_len_next;
  logic [20:0]     code_point, code_point_next;
  logic [CNT_W-1:0] copied_count, copied_count_next;
  phase_t          run_phase, run_phase_next;

  logic [3:0][7:0] pend_new;
  logic [2:0]      n_cur, seen_new;
  logic [20:0]     cp_new;
  logic            done, bad_end;
  logic [CNT_W:0]  fit_sum;
  logic [CNT_W+6:0] cnt_ext;

  assign in_ready = !qstat.full;
  assign cnt_ext  = (CNT_W + 7)'(copied_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len <= 3'd0;
      seen_len     <= 3'd0;
      code_point   <= 21'd0;
      copied_count <= '0;
      run_phase    <= PH_RUN;
    end else begin
      expected_len <= expected_len_next;
      seen_len     <= seen_len_next;
      code_point   <= code_point_next;
      copied_count <= copied_count_next;
      run_phase    <= run_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  always_comb begin
    pend_next         = pend;
    expected_len_next = expected_len;
    seen_len_next     = seen_len;
    code_point_next   = code_point;
    copied_count_next = copied_count;
    run_phase_next    = run_phase;
    push              = 1'b0;
    push_job          = '0;
    pend_new          = pend;
    n_cur             = expected_len;
    seen_new          = seen_len;
    cp_new            = code_point;
    done              = 1'b0;
    fit_sum           = '0;
    bad_end           = (run_phase != PH_RUN && run_phase != PH_FULL) ||
                        (run_phase == PH_RUN && expected_len != 3'd0);
    if (in_valid && in_ready) begin
      if (action) begin
        push              = 1'b1;
        push_job.kind     = KIND_STATUS;
        push_job.status   = bad_end;
        push_job.length   = bad_end ? 7'd0 : cnt_ext[6:0];
        expected_len_next = 3'd0;
        seen_len_next     = 3'd0;
        code_point_next   = 21'd0;
        copied_count_next = '0;
        run_phase_next    = PH_RUN;
      end else if (run_phase == PH_RUN) begin
        if (expected_len == 3'd0) begin
          n_cur = lead_length(data_byte);
          if (n_cur == 3'd0) begin
            run_phase_next = PH_FAIL;
          end else begin
            pend_new[0] = data_byte;
            seen_new    = 3'd1;
            cp_new      = {13'd0, lead_payload(data_byte, n_cur)};
            done        = (n_cur == 3'd1);
            pend_next         = pend_new;
            expected_len_next = n_cur;
            seen_len_next     = seen_new;
            code_point_next   = cp_new;
          end
        end else begin
          if (data_byte[7:6] != 2'b10 || seen_len > 3'd3) begin
            run_phase_next    = PH_FAIL;
            expected_len_next = 3'd0;
            seen_len_next     = 3'd0;
            code_point_next   = 21'd0;
          end else begin
            pend_new[seen_len[1:0]] = data_byte;
            seen_new = seen_len + 3'd1;
            cp_new   = {code_point[14:0], data_byte[5:0]};
            done     = (seen_new == expected_len);
            pend_next       = pend_new;
            seen_len_next   = seen_new;
            code_point_next = cp_new;
          end
        end
        if (done) begin
          expected_len_next = 3'd0;
          seen_len_next     = 3'd0;
          code_point_next   = 21'd0;
          fit_sum = {1'b0, copied_count} + (CNT_W + 1)'(n_cur);
          if (char_bad(cp_new, n_cur)) begin
            run_phase_next = PH_FAIL;
          end else if (fit_sum > (CNT_W + 1)'(TEXT_MAX)) begin
            run_phase_next = PH_FULL;
          end else begin
            push              = 1'b1;
            push_job.kind     = KIND_TEXT;
            push_job.bytes    = pend_new;
            push_job.n        = n_cur;
            copied_count_next = fit_sum[CNT_W-1:0];
          end
        end
      end
    end
  end

endmodule

### rtl/core/u8v_queue.sv
// u8v_queue: short job queue between the front and back parts
// depends on u8v_pkg for job_t, qstat_t and the queue depth
`timescale 1ns / 1ps

module u8v_queue import u8v_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  job_t   push_job,
  input  logic   pop,
  output job_t   head,
  output qstat_t qstat
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  assign qstat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/core/u8v_back.sv
// u8v_back: takes jobs from the queue head and sends one result per transfer
// through an output register; depends on u8v_pkg
`timescale 1ns / 1ps

module u8v_back import u8v_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  qstat_t     qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       status,
  output logic [6:0] length,
  output logic       last_of_run
);

  logic [1:0] idx;
  logic       load, cur_last;

  assign cur_last = (head.kind == KIND_STATUS) || ({1'b0, idx} + 3'd1 == head.n);
  assign load     = !qstat.empty && (!out_valid || out_ready);
  assign pop      = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= cur_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind    <= head.kind;
      last_of_run <= cur_last;
      if (head.kind == KIND_STATUS) begin
        out_byte <= 8'd0;
        status   <= head.status;
        length   <= head.length;
      end else begin
        out_byte <= head.bytes[idx];
        status   <= 1'b0;
        length   <= 7'd0;
      end
    end
  end

endmodule

### rtl/core/utf8_validating_copier.sv
// utf8_validating_copier: top level, front checker, job queue and result stage
// depends on u8v_pkg, u8v_front, u8v_queue and u8v_back
`timescale 1ns / 1ps

// Input channel: in_valid/in_ready carry one item per transfer, either a
// string byte (action 0, data_byte) or the end of the string (action 1).
// Output channel: out_valid/out_ready carry one result per transfer. Text
// bytes of each valid character come out whole (out_kind 0), with
// last_of_run on the character's final byte. The end item gives one status
// result (out_kind 1) with status and length, and clears the checker.
// A byte is taken every cycle while the four-entry job queue has room; one
// result leaves per cycle while the receiver is ready, so a character of n
// bytes gives n results. The first result of a completed character or end
// item passes through the job queue and then the output register.
// When the receiver stalls, the output register holds its result and the
// queue fills; once it is full, in_ready drops until results drain.
// Reset (rst, synchronous) empties the queue and output register and
// starts a new string with zero bytes copied.
module utf8_validating_copier import u8v_pkg::*; #(
  parameter int TEXT_MAX = TEXT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       status,
  output logic [6:0] length,
  output logic       last_of_run
);

  logic   push, pop;
  job_t   push_job, head;
  qstat_t qstat;

  u8v_front #(.TEXT_MAX(TEXT_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .data_byte (data_byte),
    .qstat     (qstat),
    .push      (push),
    .push_job  (push_job)
  );

  u8v_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  u8v_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .status      (status),
    .length      (length),
    .last_of_run (last_of_run)
  );

endmodule
